FILE: rtl/rrpd_pkg.sv
// Shared types and constants of the run ratio pattern detector.
package rrpd_pkg;

   localparam logic [7:0] WHITE_PIXEL = 8'hFF;
   localparam int         FRAC_BITS   = 16;
   localparam int         POINT_BITS  = 17;
   localparam int         CSR_BITS    = 3;
   localparam int         CSR_DATA_BITS = 18;

   localparam logic [CSR_BITS-1:0] CSR_START_X   = 3'd0;
   localparam logic [CSR_BITS-1:0] CSR_START_Y   = 3'd1;
   localparam logic [CSR_BITS-1:0] CSR_STEP_X    = 3'd2;
   localparam logic [CSR_BITS-1:0] CSR_STEP_Y    = 3'd3;
   localparam logic [CSR_BITS-1:0] CSR_MIN_BLACK = 3'd4;

   // Which candidate of a match is being produced.
   typedef enum logic [1:0] {
      CAND_OUTER,
      CAND_INNER,
      CAND_CENTER
   } rrpd_cand_type;

   // Result of the edge and ratio test for one word.
   typedef struct packed {
      logic color_edge;
      logic ratio_match;
   } rrpd_match_type;

endpackage

FILE: rtl/rrpd_ratio_check.sv
// Color edge detection and run ratio test of the five latest runs.
module rrpd_ratio_check
   import rrpd_pkg::*;
#(
   parameter int RUN_BITS = 13
) (
   input  logic                pixel_white,
   input  logic                run_white,
   input  logic [7:0]          min_black_run,
   input  logic [RUN_BITS-1:0] run_len [5],
   output rrpd_match_type      result
);

   localparam int CW = RUN_BITS + 4;

   logic [CW-1:0] c0;
   logic [CW-1:0] c1;
   logic [CW-1:0] c2;
   logic [CW-1:0] c3;
   logic [CW-1:0] c4;
   logic          long_black;
   logic          ratio_3to1;
   logic          near_02;
   logic          near_13;
   logic          near_24;

   assign c0 = CW'(run_len[0]);
   assign c1 = CW'(run_len[1]);
   assign c2 = CW'(run_len[2]);
   assign c3 = CW'(run_len[3]);
   assign c4 = CW'(run_len[4]);

   assign long_black = CW'(run_len[0]) > CW'(min_black_run);

   // center run about three times the neighbor: strictly within 0.8 .. 1.25
   assign ratio_3to1 = (c1 * CW'(12) < c0 * CW'(5)) && (c0 * CW'(4) < c1 * CW'(15));
   assign near_02    = (c2 * CW'(4) < c0 * CW'(5)) && (c0 * CW'(4) < c2 * CW'(5));
   assign near_13    = (c3 * CW'(4) < c1 * CW'(5)) && (c1 * CW'(4) < c3 * CW'(5));
   assign near_24    = (c4 * CW'(4) < c2 * CW'(5)) && (c2 * CW'(4) < c4 * CW'(5));

   assign result.color_edge  = pixel_white != run_white;
   assign result.ratio_match = result.color_edge && !run_white && long_black &&
                               ratio_3to1 && near_02 && near_13 && near_24;

endmodule

FILE: rtl/run_ratio_pattern_detector_unit.sv
// Top level of the run ratio pattern detector along a scan ray.
//
// Usage: the req channel carries one pixel word per cycle along the ray,
// with req_line_start set on the first pixel of each ray. White is a pixel
// value of 255, anything else is black. The rsp channel returns candidate
// center points (integer pixel coordinates) with rsp_last marking the final
// candidate caused by a pixel. The csr port sets ray start, signed 2.16
// step and the minimum black run; write it only while the block is idle.
// Throughput: one pixel per cycle. A pixel that closes a matching pattern
// holds req_stall while the sequencer produces all but its last candidate
// (three candidates on the first match of a ray, one afterwards).
// Path: a candidate passes from its accepted pixel through the candidate
// sequencer, the multiplier register and the output register, in order.
// Run state updates at the accept edge, so a pixel without a match waits
// on the result path only while an earlier match is in the sequencer.
// When the receiver stalls, the output register holds its word, the pipe
// behind it fills, and req_stall rises once the sequencer can not drain.
// Reset clears all runs to one, color to black, position to zero and loads
// the default configuration.
module run_ratio_pattern_detector_unit
   import rrpd_pkg::*;
#(
   parameter int RUN_BITS = 13
) (
   input  logic                         clock,
   input  logic                         reset,
   // pixel words in
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [7:0]                   req_pixel,
   input  logic                         req_line_start,
   // candidate words out
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic signed [POINT_BITS-1:0] rsp_point_x,
   output logic signed [POINT_BITS-1:0] rsp_point_y,
   output logic                         rsp_last,
   // configuration writes
   input  logic                         csr_write_en,
   input  logic [CSR_BITS-1:0]          csr_index,
   input  logic [CSR_DATA_BITS-1:0]     csr_data
);

   localparam int DW = RUN_BITS + 3;               // distance sum width
   localparam int PW = RUN_BITS + 22;              // step * distance width
   localparam int SW = (PW > 32 ? PW : 32) + 1;    // exact difference width

   // ---------------------------------------------------------------- config
   logic [11:0]        start_x_ff;
   logic [11:0]        start_y_ff;
   logic signed [17:0] step_x_ff;
   logic signed [17:0] step_y_ff;
   logic [7:0]         min_black_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_x_ff   <= '0;
         start_y_ff   <= '0;
         step_x_ff    <= 18'sd65536;
         step_y_ff    <= '0;
         min_black_ff <= 8'd20;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_START_X:   start_x_ff   <= csr_data[11:0];
            CSR_START_Y:   start_y_ff   <= csr_data[11:0];
            CSR_STEP_X:    step_x_ff    <= $signed(csr_data[17:0]);
            CSR_STEP_Y:    step_y_ff    <= $signed(csr_data[17:0]);
            CSR_MIN_BLACK: min_black_ff <= csr_data[7:0];
            default: ;
         endcase
      end
   end

   // ------------------------------------------------------------ run state
   logic [RUN_BITS-1:0] run_ff [5];
   logic [RUN_BITS-1:0] run_in [5];
   logic [RUN_BITS-1:0] run_eff [5];
   logic                white_ff;
   logic                white_in;
   logic                white_eff;
   logic                first_ff;
   logic                first_in;
   logic                first_eff;
   logic [31:0]         pos_x_ff;
   logic [31:0]         pos_x_in;
   logic [31:0]         pos_y_ff;
   logic [31:0]         pos_y_in;
   logic [31:0]         pos_x_eff;
   logic [31:0]         pos_y_eff;
   logic                pixel_white;
   logic                accept;
   rrpd_match_type      test;
   logic [DW-1:0]       dist_outer;
   logic [DW-1:0]       dist_inner;

   assign pixel_white = req_pixel == WHITE_PIXEL;

   // a ray start first resets runs, color, first flag and position
   always_comb begin
      for (int i = 0; i < 5; i++) begin
         run_eff[i] = req_line_start ? RUN_BITS'(1) : run_ff[i];
      end
      white_eff = req_line_start ? 1'b0 : white_ff;
      first_eff = req_line_start ? 1'b1 : first_ff;
      pos_x_eff = req_line_start ? {4'b0, start_x_ff, 16'b0} : pos_x_ff;
      pos_y_eff = req_line_start ? {4'b0, start_y_ff, 16'b0} : pos_y_ff;
   end

   rrpd_ratio_check #(
      .RUN_BITS (RUN_BITS)
   ) u_ratio (
      .pixel_white   (pixel_white),
      .run_white     (white_eff),
      .min_black_run (min_black_ff),
      .run_len       (run_eff),
      .result        (test)
   );

   // distances back to the outer and inner quad centers
   assign dist_outer = DW'(run_eff[0]) + DW'(run_eff[1]) + DW'(run_eff[2]) +
                       DW'(run_eff[3]) + DW'(run_eff[4] >> 1);
   assign dist_inner = DW'(run_eff[0]) + DW'(run_eff[1]) + DW'(run_eff[2] >> 1);

   always_comb begin
      // shift in a new run on a color edge, then count this pixel
      if (test.color_edge) begin
         run_in[0] = RUN_BITS'(2);
         for (int i = 1; i < 5; i++) begin
            run_in[i] = run_eff[i-1];
         end
      end else begin
         run_in[0] = (run_eff[0] != {RUN_BITS{1'b1}}) ? run_eff[0] + RUN_BITS'(1)
                                                      : run_eff[0];
         for (int i = 1; i < 5; i++) begin
            run_in[i] = run_eff[i];
         end
      end
      white_in = pixel_white;
      first_in = first_eff && !test.ratio_match;
      pos_x_in = pos_x_eff + {{14{step_x_ff[17]}}, step_x_ff};
      pos_y_in = pos_y_eff + {{14{step_y_ff[17]}}, step_y_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 5; i++) begin
            run_ff[i] <= RUN_BITS'(1);
         end
         white_ff <= 1'b0;
         first_ff <= 1'b1;
         pos_x_ff <= '0;
         pos_y_ff <= '0;
      end else if (accept) begin
         run_ff   <= run_in;
         white_ff <= white_in;
         first_ff <= first_in;
         pos_x_ff <= pos_x_in;
         pos_y_ff <= pos_y_in;
      end
   end

   // ---------------------------------------------------- handshake control
   logic b_valid_ff;
   logic b_valid_in;
   logic c_valid_ff;
   logic c_valid_in;
   logic rsp_valid_ff;
   logic rsp_valid_in;
   logic out_free;
   logic c_free;
   logic c_move;
   logic b_fire;
   logic b_done;
   rrpd_cand_type b_kind_ff;
   rrpd_cand_type b_kind_in;
   rrpd_cand_type b_kind_next;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign c_move    = c_valid_ff && out_free;
   assign c_free    = !c_valid_ff || out_free;
   assign b_fire    = b_valid_ff && c_free;
   assign b_done    = b_fire && (b_kind_ff == CAND_CENTER);
   assign req_stall = b_valid_ff && !b_done;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      unique case (b_kind_ff)
         CAND_OUTER:  b_kind_next = CAND_INNER;
         CAND_INNER:  b_kind_next = CAND_CENTER;
         CAND_CENTER: b_kind_next = CAND_CENTER;
         default:     b_kind_next = CAND_CENTER;
      endcase

      b_valid_in = b_valid_ff;
      b_kind_in  = b_kind_ff;
      if (accept && test.ratio_match) begin
         b_valid_in = 1'b1;
         b_kind_in  = first_eff ? CAND_OUTER : CAND_CENTER;
      end else if (b_done) begin
         b_valid_in = 1'b0;
      end else if (b_fire) begin
         b_kind_in = b_kind_next;
      end

      c_valid_in   = b_fire ? 1'b1 : (c_move ? 1'b0 : c_valid_ff);
      rsp_valid_in = c_move ? 1'b1 : (out_free ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff   <= 1'b0;
         b_kind_ff    <= CAND_CENTER;
         c_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         b_valid_ff   <= b_valid_in;
         b_kind_ff    <= b_kind_in;
         c_valid_ff   <= c_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // ---------------------------------------------- candidate sequencer (B)
   logic [31:0]         b_pos_x_ff;
   logic [31:0]         b_pos_y_ff;
   logic [DW-1:0]       b_outer_ff;
   logic [DW-1:0]       b_inner_ff;
   logic [RUN_BITS-1:0] b_center_ff;

   always_ff @(posedge clock) begin
      if (accept && test.ratio_match) begin
         b_pos_x_ff  <= pos_x_eff;
         b_pos_y_ff  <= pos_y_eff;
         b_outer_ff  <= dist_outer;
         b_inner_ff  <= dist_inner;
         b_center_ff <= run_eff[0];
      end
   end

   logic [DW-1:0]        dist_sel;
   logic signed [PW-1:0] step_x_ext;
   logic signed [PW-1:0] step_y_ext;
   logic signed [PW-1:0] dist_ext;
   logic signed [PW-1:0] prod_x_in;
   logic signed [PW-1:0] prod_y_in;

   always_comb begin
      unique case (b_kind_ff)
         CAND_OUTER:  dist_sel = b_outer_ff;
         CAND_INNER:  dist_sel = b_inner_ff;
         CAND_CENTER: dist_sel = DW'(b_center_ff);
         default:     dist_sel = b_outer_ff;
      endcase
   end

   assign step_x_ext = PW'(step_x_ff);
   assign step_y_ext = PW'(step_y_ff);
   assign dist_ext   = $signed(PW'(dist_sel));
   assign prod_x_in  = step_x_ext * dist_ext;
   assign prod_y_in  = step_y_ext * dist_ext;

   // ------------------------------------------------ product register (C)
   logic signed [PW-1:0] c_prod_x_ff;
   logic signed [PW-1:0] c_prod_y_ff;
   logic [31:0]          c_pos_x_ff;
   logic [31:0]          c_pos_y_ff;
   logic                 c_half_ff;

   always_ff @(posedge clock) begin
      if (b_fire) begin
         c_prod_x_ff <= prod_x_in;
         c_prod_y_ff <= prod_y_in;
         c_pos_x_ff  <= b_pos_x_ff;
         c_pos_y_ff  <= b_pos_y_ff;
         c_half_ff   <= b_kind_ff == CAND_CENTER;
      end
   end

   // center offset halves toward zero: floor shift plus one for odd negatives
   logic signed [PW-1:0] off_x;
   logic signed [PW-1:0] off_y;
   logic                 borrow_x;
   logic                 borrow_y;
   logic [SW-1:0]        diff_x;
   logic [SW-1:0]        diff_y;

   always_comb begin
      off_x    = c_half_ff ? (c_prod_x_ff >>> 1) : c_prod_x_ff;
      off_y    = c_half_ff ? (c_prod_y_ff >>> 1) : c_prod_y_ff;
      borrow_x = c_half_ff && c_prod_x_ff[PW-1] && c_prod_x_ff[0];
      borrow_y = c_half_ff && c_prod_y_ff[PW-1] && c_prod_y_ff[0];
      diff_x   = SW'($signed(c_pos_x_ff)) - SW'(off_x) - {{(SW-1){1'b0}}, borrow_x};
      diff_y   = SW'($signed(c_pos_y_ff)) - SW'(off_y) - {{(SW-1){1'b0}}, borrow_y};
   end

   // ------------------------------------------------- output register (D)
   logic signed [POINT_BITS-1:0] rsp_point_x_ff;
   logic signed [POINT_BITS-1:0] rsp_point_y_ff;
   logic                         rsp_last_ff;

   always_ff @(posedge clock) begin
      if (c_move) begin
         rsp_point_x_ff <= $signed(diff_x[FRAC_BITS +: POINT_BITS]);
         rsp_point_y_ff <= $signed(diff_y[FRAC_BITS +: POINT_BITS]);
         rsp_last_ff    <= c_half_ff;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_point_x = rsp_point_x_ff;
   assign rsp_point_y = rsp_point_y_ff;
   assign rsp_last    = rsp_last_ff;

endmodule
